[hdl/mrfb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrfb_pkg
// Shared types, codes and the CRC-16/MODBUS byte update for the frame builder.
// ----------------------------------------------------------------------------
package mrfb_pkg;

   // Request layout codes
   localparam logic [2:0] OP_READ     = 3'd0;
   localparam logic [2:0] OP_WRITE1   = 3'd1;
   localparam logic [2:0] OP_MULTI1   = 3'd2;
   localparam logic [2:0] OP_MULTI2   = 3'd3;
   localparam logic [2:0] OP_MULTI4   = 3'd4;

   // Frame sizing: data bytes before the two CRC bytes
   localparam int          DATA_MAX     = 15;
   localparam logic [3:0]  LEN_SHORT    = 4'd6;
   localparam logic [3:0]  LEN_MULTI1   = 4'd9;
   localparam logic [3:0]  LEN_MULTI2   = 4'd11;
   localparam logic [3:0]  LEN_MULTI4   = 4'd15;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;

   // One queued request, already classified
   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  data_len;
      logic [7:0]  slave_id;
      logic [7:0]  function_code;
      logic [15:0] reg_address;
      logic [15:0] reg_quantity;
      logic [7:0]  byte_count;
      logic [15:0] data_word0;
      logic [15:0] data_word1;
      logic [15:0] data_word2;
      logic [15:0] data_word3;
   } req_entry_type;

   // Bytewise reflected CRC update (eight shift steps)
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hdl/mrfb_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrfb_front
// Accepts requests, drops undefined layouts, sizes the frame and holds
// classified requests in a two-entry queue. Also owns the slave id register.
// ----------------------------------------------------------------------------
module mrfb_front
   import mrfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // configuration
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_slave_id,
   // request channel
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [2:0]    req_opcode,
   input  wire logic [7:0]    req_function_code,
   input  wire logic [15:0]   req_reg_address,
   input  wire logic [15:0]   req_reg_quantity,
   input  wire logic [7:0]    req_byte_count,
   input  wire logic [15:0]   req_data_word0,
   input  wire logic [15:0]   req_data_word1,
   input  wire logic [15:0]   req_data_word2,
   input  wire logic [15:0]   req_data_word3,
   // queue head toward the back end
   output logic               head_valid,
   output req_entry_type      head_entry,
   input  wire logic          head_pop
);

   logic [7:0]    slave_id_ff, slave_id_in;
   req_entry_type queue_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          accept;
   logic          legal;
   logic          push;
   logic [3:0]    data_len;
   req_entry_type new_entry;

   assign csr_ready = 1'b1;
   assign req_ready = (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;

   // Classify the layout
   always_comb begin
      legal    = 1'b1;
      data_len = LEN_SHORT;
      case (req_opcode)
         OP_READ, OP_WRITE1: data_len = LEN_SHORT;
         OP_MULTI1:          data_len = LEN_MULTI1;
         OP_MULTI2:          data_len = LEN_MULTI2;
         OP_MULTI4:          data_len = LEN_MULTI4;
         default:            legal    = 1'b0;
      endcase
   end

   assign push = accept && legal;

   always_comb begin
      new_entry.opcode        = req_opcode;
      new_entry.data_len      = data_len;
      new_entry.slave_id      = slave_id_ff;
      new_entry.function_code = req_function_code;
      new_entry.reg_address   = req_reg_address;
      new_entry.reg_quantity  = req_reg_quantity;
      new_entry.byte_count    = req_byte_count;
      new_entry.data_word0    = req_data_word0;
      new_entry.data_word1    = req_data_word1;
      new_entry.data_word2    = req_data_word2;
      new_entry.data_word3    = req_data_word3;
   end

   // Queue pointers
   always_comb begin
      slave_id_in = (csr_valid && csr_ready) ? csr_slave_id : slave_id_ff;
      wr_ptr_in   = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in    = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= 8'h01;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         slave_id_ff <= slave_id_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_entry = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

[hdl/mrfb_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrfb_back
// Serializes the queue head one byte per cycle unless stalled, folds each data
// byte into the running CRC, appends CRC low and high bytes. Output registered.
// ----------------------------------------------------------------------------
module mrfb_back
   import mrfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // queue head
   input  wire logic          head_valid,
   input  wire req_entry_type head_entry,
   output logic               head_pop,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last_byte
);

   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        advance;
   logic        emit;
   logic [7:0]  frame [DATA_MAX];
   logic [4:0]  len_ext;
   logic [7:0]  data_byte;

   assign advance = !valid_ff || rsp_ready;
   assign emit    = advance && head_valid;
   assign len_ext = {1'b0, head_entry.data_len};

   // Data bytes of the frame by layout
   always_comb begin
      for (int i = 0; i < DATA_MAX; i++) begin
         frame[i] = 8'h00;
      end
      frame[0] = head_entry.slave_id;
      frame[1] = head_entry.function_code;
      frame[2] = head_entry.reg_address[15:8];
      frame[3] = head_entry.reg_address[7:0];
      case (head_entry.opcode)
         OP_READ: begin
            frame[4] = 8'h00;
            frame[5] = head_entry.byte_count;
         end
         OP_WRITE1: begin
            frame[4] = head_entry.data_word0[15:8];
            frame[5] = head_entry.data_word0[7:0];
         end
         default: begin
            frame[4]  = head_entry.reg_quantity[15:8];
            frame[5]  = head_entry.reg_quantity[7:0];
            frame[6]  = head_entry.byte_count;
            frame[7]  = head_entry.data_word0[15:8];
            frame[8]  = head_entry.data_word0[7:0];
            frame[9]  = head_entry.data_word1[15:8];
            frame[10] = head_entry.data_word1[7:0];
            frame[11] = head_entry.data_word2[15:8];
            frame[12] = head_entry.data_word2[7:0];
            frame[13] = head_entry.data_word3[15:8];
            frame[14] = head_entry.data_word3[7:0];
         end
      endcase
   end

   assign data_byte = (idx_ff[3:0] == 4'd15) ? 8'h00 : frame[idx_ff[3:0]];

   // Byte sequencer
   always_comb begin
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      head_pop = 1'b0;
      if (advance) begin
         valid_in = head_valid;
      end
      if (emit) begin
         idx_in  = idx_ff + 5'd1;
         last_in = 1'b0;
         if (idx_ff < len_ext) begin
            byte_in = data_byte;
            crc_in  = crc_update(crc_ff, data_byte);
         end else if (idx_ff == len_ext) begin
            byte_in = crc_ff[7:0];
         end else begin
            // CRC high byte closes the frame
            byte_in  = crc_ff[15:8];
            last_in  = 1'b1;
            idx_in   = 5'd0;
            crc_in   = CRC_INIT;
            head_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 5'd0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule
`default_nettype wire

[hdl/modbus_request_frame_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_request_frame_builder
// Turns one Modbus master request into its RTU frame with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_ channel writes the slave id (reset value 1); always ready. Write it
//    only while no frame is in flight.
//  - req_ channel takes one request: opcode selects the layout (read, single
//    write, multi write with 1/2/4 words). Undefined opcodes are accepted and
//    produce no frame.
//  - rsp_ channel emits the frame bytes in order; rsp_last_byte marks the
//    CRC high byte that closes each frame.
//  - A request is written into the queue at the accepting edge; its first
//    byte then leaves through the output register.
//  - Throughput: one byte per cycle from the serializer unless the receiver
//    stalls; a frame is 8, 11, 13 or 17 bytes. The serializer with its
//    bytewise CRC update sets that rate. A two-entry queue lets the next
//    request be taken while the current frame drains.
//  - When the receiver stalls, the output byte holds and the serializer
//    waits; requests keep being taken until the queue is full.
//  - Reset empties the queue, drops the output valid and restores slave id 1.
// ----------------------------------------------------------------------------
module modbus_request_frame_builder
   import mrfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_slave_id,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [2:0]    req_opcode,
   input  wire logic [7:0]    req_function_code,
   input  wire logic [15:0]   req_reg_address,
   input  wire logic [15:0]   req_reg_quantity,
   input  wire logic [7:0]    req_byte_count,
   input  wire logic [15:0]   req_data_word0,
   input  wire logic [15:0]   req_data_word1,
   input  wire logic [15:0]   req_data_word2,
   input  wire logic [15:0]   req_data_word3,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last_byte
);

   logic          head_valid;
   logic          head_pop;
   req_entry_type head_entry;

   // Front end: accept, classify, queue
   mrfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_slave_id      (csr_slave_id),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_function_code (req_function_code),
      .req_reg_address   (req_reg_address),
      .req_reg_quantity  (req_reg_quantity),
      .req_byte_count    (req_byte_count),
      .req_data_word0    (req_data_word0),
      .req_data_word1    (req_data_word1),
      .req_data_word2    (req_data_word2),
      .req_data_word3    (req_data_word3),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .head_pop          (head_pop)
   );

   // Back end: serialize and append CRC
   mrfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .head_pop      (head_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
`default_nettype wire

[dv/tb_modbus_request_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_request_frame_builder
// Self-checking bench for the Modbus RTU request frame builder. Requests are
// driven on the req_ channel in random bursts. Each accepted request is
// expanded by a local frame predictor into the bytes it should produce,
// including the CRC-16/MODBUS pair, low byte first. Every byte taken on the
// rsp_ channel is compared against the oldest predicted byte. The receiver
// stalls at random rates, and once it holds off long enough to back up the
// request queue. The slave id register is rewritten between traffic phases.
// ----------------------------------------------------------------------------
module tb_modbus_request_frame_builder;
   import mrfb_pkg::*;

   // Opcode values beyond the defined layouts produce no frame
   localparam logic [2:0] OP_FIELD_MAX      = 3'd7;
   // Function codes used to build deliberately inconsistent requests
   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;
   localparam int         CYCLE_LIMIT       = 400000;
   localparam int         DRAIN_TAIL        = 6;
   localparam int         REPORT_MAX        = 10;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [7:0]        function_code;
      logic [15:0]       reg_address;
      logic [15:0]       reg_quantity;
      logic [7:0]        byte_count;
      logic [3:0][15:0]  data_words;
   } modbus_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } frame_byte_type;

   logic          clock;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   logic [7:0]    csr_slave_id;
   logic          req_valid;
   logic          req_ready;
   logic [2:0]    req_opcode;
   logic [7:0]    req_function_code;
   logic [15:0]   req_reg_address;
   logic [15:0]   req_reg_quantity;
   logic [7:0]    req_byte_count;
   logic [15:0]   req_data_word0;
   logic [15:0]   req_data_word1;
   logic [15:0]   req_data_word2;
   logic [15:0]   req_data_word3;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [7:0]    rsp_tx_byte;
   logic          rsp_last_byte;

   frame_byte_type pending_frame_bytes[$];
   frame_byte_type next_frame_byte;
   logic [7:0]     shadow_slave_id;
   int             error_count = 0;
   int             cycle_count = 0;
   int             rsp_hold_cycles = 0;

   modbus_request_frame_builder dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_slave_id      (csr_slave_id),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_function_code (req_function_code),
      .req_reg_address   (req_reg_address),
      .req_reg_quantity  (req_reg_quantity),
      .req_byte_count    (req_byte_count),
      .req_data_word0    (req_data_word0),
      .req_data_word1    (req_data_word1),
      .req_data_word2    (req_data_word2),
      .req_data_word3    (req_data_word3),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_byte     (rsp_last_byte)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Frame predictor
   // ------------------------------------------------------------------------

   // CRC-16/MODBUS, one data bit at a time, LSB first
   function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                     input logic [7:0]  data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ data[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Expand one request into its frame bytes and queue them
   function automatic void build_expected_frame(input modbus_req_type r);
      logic [7:0]     frame[$];
      logic [15:0]    crc;
      int             n_words;
      frame_byte_type fb;
      // undefined layouts produce nothing
      if (r.opcode > OP_MULTI4) begin
         return;
      end
      frame.push_back(shadow_slave_id);
      frame.push_back(r.function_code);
      frame.push_back(r.reg_address[15:8]);
      frame.push_back(r.reg_address[7:0]);
      case (r.opcode)
         OP_READ: begin
            frame.push_back(8'h00);
            frame.push_back(r.byte_count);
         end
         OP_WRITE1: begin
            frame.push_back(r.data_words[0][15:8]);
            frame.push_back(r.data_words[0][7:0]);
         end
         default: begin
            frame.push_back(r.reg_quantity[15:8]);
            frame.push_back(r.reg_quantity[7:0]);
            frame.push_back(r.byte_count);
            n_words = (r.opcode == OP_MULTI1) ? 1 : (r.opcode == OP_MULTI2) ? 2 : 4;
            for (int w = 0; w < n_words; w++) begin
               frame.push_back(r.data_words[w][15:8]);
               frame.push_back(r.data_words[w][7:0]);
            end
         end
      endcase
      crc = CRC_INIT;
      foreach (frame[i]) begin
         crc = crc16_modbus_step(crc, frame[i]);
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      foreach (frame[i]) begin
         fb.tx_byte   = frame[i];
         fb.last_byte = (i == frame.size() - 1);
         pending_frame_bytes.push_back(fb);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frame_bytes.size() == 0) begin
            note_error($sformatf("unexpected byte %02h last %0b", rsp_tx_byte,
                                 rsp_last_byte));
         end else begin
            next_frame_byte = pending_frame_bytes.pop_front();
            if (rsp_tx_byte !== next_frame_byte.tx_byte) begin
               note_error($sformatf("tx_byte expected %02h actual %02h",
                                    next_frame_byte.tx_byte, rsp_tx_byte));
            end
            if (rsp_last_byte !== next_frame_byte.last_byte) begin
               note_error($sformatf("last_byte expected %0b actual %0b",
                                    next_frame_byte.last_byte, rsp_last_byte));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall rate changes in random-length phases; a long hold-off
   // can be requested through rsp_hold_cycles
   // ------------------------------------------------------------------------
   initial begin
      int stall_pct;
      int phase_left;
      rsp_ready  = 1'b0;
      stall_pct  = 0;
      phase_left = 0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 200);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 25;
               3:       stall_pct = 50;
               default: stall_pct = 80;
            endcase
         end
         phase_left--;
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Random value of the given width, biased toward all zeros and all ones
   function automatic logic [15:0] rand_field(input int bits);
      logic [15:0] mask;
      mask = 16'((32'd1 << bits) - 1);
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return mask;
         default: return 16'($urandom) & mask;
      endcase
   endfunction

   function automatic modbus_req_type random_request();
      modbus_req_type r;
      if ($urandom_range(0, 11) == 0) begin
         r.opcode = 3'($urandom_range(OP_MULTI4 + 1, OP_FIELD_MAX));
      end else begin
         r.opcode = 3'($urandom_range(OP_READ, OP_MULTI4));
      end
      r.function_code = 8'(rand_field(8));
      r.reg_address   = rand_field(16);
      r.reg_quantity  = rand_field(16);
      r.byte_count    = 8'(rand_field(8));
      for (int w = 0; w < 4; w++) begin
         r.data_words[w] = rand_field(16);
      end
      return r;
   endfunction

   // Offer one request and hold it until taken; valid stays high afterwards
   // until the next negedge, where the caller either sends again or idles
   task automatic send_request(input modbus_req_type r);
      @(negedge clock);
      req_valid         = 1'b1;
      req_opcode        = r.opcode;
      req_function_code = r.function_code;
      req_reg_address   = r.reg_address;
      req_reg_quantity  = r.reg_quantity;
      req_byte_count    = r.byte_count;
      req_data_word0    = r.data_words[0];
      req_data_word1    = r.data_words[1];
      req_data_word2    = r.data_words[2];
      req_data_word3    = r.data_words[3];
      do @(posedge clock); while (!req_ready);
      build_expected_frame(r);
   endtask

   task automatic req_idle(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Stop sending and let every predicted byte come out
   task automatic wait_frames_done();
      req_idle(1);
      while (pending_frame_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // Slave id write; only called with the block idle
   task automatic write_slave_id(input logic [7:0] id);
      @(negedge clock);
      csr_valid    = 1'b1;
      csr_slave_id = id;
      do @(posedge clock); while (!csr_ready);
      shadow_slave_id = id;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Frame right after reset uses the reset slave id
   task automatic test_default_slave_id();
      modbus_req_type r;
      r        = random_request();
      r.opcode = OP_READ;
      send_request(r);
   endtask

   // One request of each defined layout
   task automatic test_frame_layouts();
      modbus_req_type r;
      for (int op = OP_READ; op <= OP_MULTI4; op++) begin
         r        = random_request();
         r.opcode = 3'(op);
         send_request(r);
      end
   endtask

   // All-zero and all-one field values
   task automatic test_field_extremes();
      modbus_req_type r;
      r        = '0;
      r.opcode = OP_MULTI4;
      send_request(r);
      r        = '1;
      r.opcode = OP_MULTI4;
      send_request(r);
      r        = '1;
      r.opcode = OP_READ;
      send_request(r);
      r        = '0;
      r.opcode = OP_WRITE1;
      send_request(r);
   endtask

   // Undefined opcodes are swallowed; the next frame must follow cleanly
   task automatic test_undefined_opcodes();
      modbus_req_type r;
      for (int op = OP_MULTI4 + 1; op <= OP_FIELD_MAX; op++) begin
         r        = random_request();
         r.opcode = 3'(op);
         send_request(r);
      end
      r        = random_request();
      r.opcode = OP_WRITE1;
      send_request(r);
   endtask

   // Function code, quantity and byte count are passed through unchecked
   task automatic test_unchecked_fields();
      modbus_req_type r;
      r               = random_request();
      r.opcode        = OP_MULTI4;
      r.function_code = FC_READ_HOLDING;
      r.reg_quantity  = 16'hFFFF;
      r.byte_count    = 8'h00;
      send_request(r);
      r               = random_request();
      r.opcode        = OP_READ;
      r.function_code = FC_WRITE_MULTIPLE;
      send_request(r);
   endtask

   // Slave id at both ends of its range
   task automatic test_slave_id_extremes();
      modbus_req_type r;
      wait_frames_done();
      write_slave_id(8'h00);
      r        = random_request();
      r.opcode = OP_MULTI2;
      send_request(r);
      wait_frames_done();
      write_slave_id(8'hFF);
      r        = random_request();
      r.opcode = OP_MULTI1;
      send_request(r);
   endtask

   // Long receiver hold-off while requests keep coming: input must stall
   task automatic test_output_backpressure();
      modbus_req_type r;
      wait_frames_done();
      rsp_hold_cycles = 300;
      repeat (6) begin
         r        = random_request();
         r.opcode = OP_MULTI4;
         send_request(r);
      end
      wait_frames_done();
   endtask

   // Random bursts over several slave id settings
   task automatic test_random_traffic();
      modbus_req_type r;
      logic [7:0]     phase_ids[4];
      int             sent;
      int             burst;
      int             gap;
      phase_ids[0] = 8'($urandom_range(2, 254));
      phase_ids[1] = 8'h00;
      phase_ids[2] = 8'hFF;
      phase_ids[3] = 8'h01;
      foreach (phase_ids[p]) begin
         wait_frames_done();
         write_slave_id(phase_ids[p]);
         sent = 0;
         while (sent < 70) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 8);
            repeat (burst) begin
               r = random_request();
               send_request(r);
               if (r.opcode <= OP_MULTI4) begin
                  sent++;
               end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            req_idle(gap);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_slave_id      = 8'h00;
      req_valid         = 1'b0;
      req_opcode        = OP_READ;
      req_function_code = 8'h00;
      req_reg_address   = 16'h0000;
      req_reg_quantity  = 16'h0000;
      req_byte_count    = 8'h00;
      req_data_word0    = 16'h0000;
      req_data_word1    = 16'h0000;
      req_data_word2    = 16'h0000;
      req_data_word3    = 16'h0000;
      shadow_slave_id   = 8'h01;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_slave_id();
      test_frame_layouts();
      test_field_extremes();
      test_undefined_opcodes();
      test_unchecked_fields();
      test_slave_id_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_frames_done();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/mrfb_pkg.sv
hdl/mrfb_front.sv
hdl/mrfb_back.sv
hdl/modbus_request_frame_builder.sv
dv/tb_modbus_request_frame_builder.sv
